/* src/ble_pkg.sv */
// types and constants shared by the list engine modules
// depends on nothing
package ble_pkg;

  typedef enum logic [3:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_DEL_HEAD = 4'd2,
    CMD_DEL_TAIL = 4'd3,
    CMD_FIND     = 4'd4,
    CMD_DEL_VAL  = 4'd5,
    CMD_READ_AT  = 4'd6,
    CMD_COUNT    = 4'd7,
    CMD_EVEN_SUM = 4'd8,
    CMD_CLEAR    = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHR  = 2'd1,
    CELL_SHL  = 2'd2,
    CELL_WR   = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2
  } state_e;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] data_value;
    logic [5:0]         position;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [5:0]         found_position;
    logic [6:0]         entry_count;
  } out_beat_t;

  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] data;
  } cell_ctrl_t;

endpackage

/* src/ble_cell.sv */
// one storage cell of the list chain
// depends on ble_pkg
module ble_cell import ble_pkg::*; #(
  parameter int IW = 6,
  parameter int K  = 0
) (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [IW-1:0]      idx_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] q_o
);

  logic signed [31:0] val_d, val_q;

  always_comb begin
    case (ctrl_i.op)
      CELL_HOLD: val_d = val_q;
      CELL_SHR:  val_d = left_i;
      CELL_SHL:  val_d = (idx_i <= IW'(K)) ? right_i : val_q;
      CELL_WR:   val_d = (idx_i == IW'(K)) ? ctrl_i.data : val_q;
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign q_o = val_q;

endmodule

/* src/ble_chain.sv */
// row of cells holding the list, head in cell 0, wrapping at the tail
// depends on ble_pkg and ble_cell
module ble_chain import ble_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [IW-1:0]      idx_i,
  output logic signed [31:0] head_o
);

  logic signed [31:0] q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [31:0] left, right;
    if (k == 0) begin : g_first
      assign left = ctrl_i.data;
    end else begin : g_mid
      assign left = q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = q[0];
    end else begin : g_inner
      assign right = q[k+1];
    end
    ble_cell #(.IW(IW), .K(k)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (idx_i),
      .left_i  (left),
      .right_i (right),
      .q_o     (q[k])
    );
  end

  assign head_o = q[0];

endmodule

/* src/ble_ctrl.sv */
// command sequencer, occupancy count and result register
// depends on ble_pkg
module ble_ctrl import ble_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_beat_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_beat_t          out_data_o,
  input  logic signed [31:0] head_i,
  output cell_ctrl_t         cell_ctrl_o,
  output logic [IW-1:0]      cell_idx_o,
  output logic [CW-1:0]      count_o
);

  localparam int PW = (CW > 6) ? CW : 6;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  state_e             state_d, state_q;
  logic [CW-1:0]      cnt_d, cnt_q;
  logic               ov_d, ov_q;
  out_beat_t          out_d, out_q;
  logic [IW-1:0]      i_d, i_q;
  logic [IW-1:0]      tgt_d, tgt_q;
  logic [IW-1:0]      fpos_d, fpos_q;
  logic               found_d, found_q;
  logic signed [31:0] sum_d, sum_q;
  logic signed [31:0] res_d, res_q;
  logic [3:0]         cmd_d, cmd_q;
  logic signed [31:0] val_d, val_q;

  logic               emit;
  status_e            e_status;
  logic signed [31:0] e_res;
  logic [IW-1:0]      e_fpos;
  logic               full, empty, accept;

  assign full       = (cnt_q == CW'(DEPTH));
  assign empty      = (cnt_q == '0);
  assign in_ready_o = (state_q == S_IDLE) && (!ov_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    tgt_d   = tgt_q;
    fpos_d  = fpos_q;
    found_d = found_q;
    sum_d   = sum_q;
    res_d   = res_q;
    cmd_d   = cmd_q;
    val_d   = val_q;
    emit     = 1'b0;
    e_status = ST_OK;
    e_res    = '0;
    e_fpos   = '0;
    cell_ctrl_o.op   = CELL_HOLD;
    cell_ctrl_o.data = in_data_i.data_value;
    cell_idx_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = in_data_i.command;
          val_d   = in_data_i.data_value;
          i_d     = '0;
          found_d = 1'b0;
          fpos_d  = '0;
          sum_d   = '0;
          res_d   = '0;
          case (in_data_i.command)
            CMD_INS_HEAD: begin
              emit = 1'b1;
              if (full) begin
                e_status = ST_FULL;
              end else begin
                cell_ctrl_o.op = CELL_SHR;
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_INS_TAIL: begin
              emit = 1'b1;
              if (full) begin
                e_status = ST_FULL;
              end else begin
                cell_ctrl_o.op = CELL_WR;
                cell_idx_o = IW'(cnt_q);
                cnt_d = cnt_q + 1'b1;
              end
            end
            CMD_DEL_HEAD: begin
              emit = 1'b1;
              if (empty) begin
                e_status = ST_MISS;
              end else begin
                e_res = head_i;
                cell_ctrl_o.op = CELL_SHL;
                cnt_d = cnt_q - 1'b1;
              end
            end
            CMD_DEL_TAIL: begin
              if (empty) begin
                emit = 1'b1;
                e_status = ST_MISS;
              end else begin
                tgt_d = IW'(cnt_q - 1'b1);
                state_d = S_SCAN;
              end
            end
            CMD_READ_AT: begin
              if (PW'(in_data_i.position) >= PW'(cnt_q)) begin
                emit = 1'b1;
                e_status = ST_MISS;
              end else begin
                tgt_d = IW'(in_data_i.position);
                state_d = S_SCAN;
              end
            end
            CMD_FIND, CMD_DEL_VAL, CMD_EVEN_SUM: begin
              state_d = S_SCAN;
            end
            CMD_CLEAR: begin
              emit = 1'b1;
              cnt_d = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // full rotation, so every entry passes the head once
        cell_ctrl_o.op = CELL_SHL;
        if (CW'(i_q) < cnt_q) begin
          if ((cmd_q == CMD_FIND || cmd_q == CMD_DEL_VAL) && !found_q && head_i == val_q) begin
            found_d = 1'b1;
            fpos_d  = i_q;
          end
          if (cmd_q == CMD_EVEN_SUM && !head_i[0]) begin
            sum_d = sum_q + head_i;
          end
          if (i_q == tgt_q) begin
            res_d = head_i;
          end
        end
        i_d = i_q + 1'b1;
        if (i_q == LAST) begin
          state_d = S_IDLE;
          if (cmd_q == CMD_DEL_VAL && found_d) begin
            state_d = S_SHIFT;
          end else begin
            emit = 1'b1;
            case (cmd_q)
              CMD_FIND: begin
                e_status = found_d ? ST_OK : ST_MISS;
                e_fpos   = fpos_d;
              end
              CMD_DEL_VAL: e_status = ST_MISS;
              CMD_EVEN_SUM: e_res = sum_d;
              CMD_READ_AT: e_res = res_d;
              CMD_DEL_TAIL: begin
                e_res = res_d;
                cnt_d = cnt_q - 1'b1;
              end
              default: e_status = ST_OK;
            endcase
          end
        end
      end
      S_SHIFT: begin
        cell_ctrl_o.op = CELL_SHL;
        cell_idx_o = fpos_q;
        cnt_d  = cnt_q - 1'b1;
        emit   = 1'b1;
        e_res  = val_q;
        e_fpos = fpos_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    ov_d  = ov_q && !out_ready_i;
    out_d = out_q;
    if (emit) begin
      ov_d = 1'b1;
      out_d.status         = e_status;
      out_d.result_value   = e_res;
      out_d.found_position = 6'(e_fpos);
      out_d.entry_count    = 7'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    i_q     <= i_d;
    tgt_q   <= tgt_d;
    fpos_q  <= fpos_d;
    found_q <= found_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    cmd_q   <= cmd_d;
    val_q   <= val_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign count_o     = cnt_q;

endmodule

/* src/bounded_list_engine.sv */
// top level of the bounded list engine: sequencer plus chain of cells
// depends on ble_pkg, ble_ctrl, ble_chain
//
// usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) carries one command
//   beat; out channel (out_valid_o / out_ready_i / out_data_o) returns
//   exactly one result beat per command, in command order.
//   insert, remove at head, count, clear, unused codes and early failures
//   are answered from idle; the result shows in the cycle after the beat
//   is taken. remove at tail, read at, find, even sum and remove value
//   rotate the whole chain once past the head cell (state S_SCAN) before
//   the result is registered, and remove value adds a closing shift
//   (state S_SHIFT) when a match is found.
//   one command is in work at a time; a new beat is taken when the engine
//   is idle and the result register is empty or being drained.
//   reset empties the list at once; cell contents are left as they are.
//   a stalled receiver holds the result beat and blocks new commands.
module bounded_list_engine import ble_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cell_ctrl_t         cell_ctrl;
  logic [IW-1:0]      cell_idx;
  logic signed [31:0] head;
  logic [CW-1:0]      count;

  ble_ctrl #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .head_i      (head),
    .cell_ctrl_o (cell_ctrl),
    .cell_idx_o  (cell_idx),
    .count_o     (count)
  );

  ble_chain #(.DEPTH(DEPTH), .IW(IW)) u_chain (
    .clk_i  (clk_i),
    .ctrl_i (cell_ctrl),
    .idx_i  (cell_idx),
    .head_o (head)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && count != CW'(DEPTH) &&
     (in_data_i.command == CMD_INS_HEAD || in_data_i.command == CMD_INS_TAIL))
    |=> count == $past(count) + 1'b1 && out_valid_o)
    else $error("insert did not grow the list");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.command == CMD_CLEAR)
    |=> count == '0 && out_data_o.entry_count == '0)
    else $error("clear left entries");

endmodule

/* tb/sv/tb_bounded_list_engine.sv */
`timescale 1ns / 100ps
// self-checking testbench for bounded_list_engine: directed table, then random command mix
// keeps its own mirror of the list and checks every result beat against it or against a pinned table row
// depends on ble_pkg and bounded_list_engine
module tb_bounded_list_engine;
  import ble_pkg::*;

  localparam int DEPTH = 64;
  localparam int PHASE_ITEMS = 140;
  localparam int MIXED_RUN = 20;
  localparam int STALL_LIMIT = 4000;
  localparam logic [3:0] CMD_LAST_CODE = 4'hF;
  localparam int POOL_N = 8;
  localparam logic signed [31:0] VALUE_POOL [POOL_N] = '{
    32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd0, 32'sd1, 32'sd2, -32'sd2, 32'sh55aa0f0e
  };

  typedef struct {
    in_beat_t  beat;
    bit        pinned;
    out_beat_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready_o;
  in_beat_t  in_data;
  logic      out_valid_o;
  logic      out_ready;
  out_beat_t out_data_o;

  logic signed [31:0] list_mirror [$];
  out_beat_t          want_q [$];
  dir_row_t           dir_rows [$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 items_sent;
  int                 fail_count;
  int                 quiet_cycles;

  bounded_list_engine #(.DEPTH(DEPTH)) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_beat_t apply_command(in_beat_t b);
    out_beat_t r;
    int hit;
    r = '0;
    hit = -1;
    if (b.command == CMD_FIND || b.command == CMD_DEL_VAL) begin
      foreach (list_mirror[i]) begin
        if (hit < 0 && list_mirror[i] == b.data_value) hit = i;
      end
    end
    case (b.command)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (list_mirror.size() >= DEPTH) r.status = ST_FULL;
        else if (b.command == CMD_INS_HEAD) list_mirror.push_front(b.data_value);
        else list_mirror.push_back(b.data_value);
      end
      CMD_DEL_HEAD: begin
        if (list_mirror.size() == 0) r.status = ST_MISS;
        else r.result_value = list_mirror.pop_front();
      end
      CMD_DEL_TAIL: begin
        if (list_mirror.size() == 0) r.status = ST_MISS;
        else r.result_value = list_mirror.pop_back();
      end
      CMD_FIND: begin
        if (hit < 0) r.status = ST_MISS;
        else r.found_position = hit[5:0];
      end
      CMD_DEL_VAL: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.found_position = hit[5:0];
          r.result_value = b.data_value;
          list_mirror.delete(hit);
        end
      end
      CMD_READ_AT: begin
        if (b.position >= list_mirror.size()) r.status = ST_MISS;
        else r.result_value = list_mirror[b.position];
      end
      CMD_EVEN_SUM: begin
        foreach (list_mirror[i]) begin
          if (!list_mirror[i][0]) r.result_value += list_mirror[i];
        end
      end
      CMD_CLEAR: list_mirror.delete();
      default: ;
    endcase
    r.entry_count = 7'(list_mirror.size());
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [3:0] c, logic signed [31:0] v, logic [5:0] p,
                                       bit pinned, status_e s, logic [6:0] n);
    dir_row_t d;
    d.beat.command = c;
    d.beat.data_value = v;
    d.beat.position = p;
    d.pinned = pinned;
    d.want = '0;
    d.want.status = s;
    d.want.entry_count = n;
    return d;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        if (list_mirror.size() != 0) return list_mirror[$urandom_range(list_mirror.size() - 1)];
        else return $urandom;
      end
      default: return VALUE_POOL[$urandom_range(POOL_N - 1)];
    endcase
  endfunction

  function automatic in_beat_t mixed_beat();
    in_beat_t b;
    if ($urandom_range(19) == 0)
      b.command = 4'($urandom_range(int'(CMD_LAST_CODE), int'(CMD_CLEAR) + 1));
    else
      b.command = 4'($urandom_range(int'(CMD_CLEAR), int'(CMD_INS_HEAD)));
    b.data_value = pick_value();
    if (list_mirror.size() != 0 && $urandom_range(1))
      b.position = 6'($urandom_range(list_mirror.size() - 1));
    else
      b.position = 6'($urandom_range(63));
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b, input bit pinned, input out_beat_t pin_val);
    out_beat_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
    predicted = apply_command(b);
    want_q.push_back(pinned ? pin_val : predicted);
    items_sent++;
  endtask

  task automatic send_random(input in_beat_t b);
    send_beat(b, 1'b0, '0);
  endtask

  task automatic fill_run();
    in_beat_t b;
    repeat (DEPTH + 3) begin
      b.command = $urandom_range(1) ? CMD_INS_HEAD : CMD_INS_TAIL;
      b.data_value = pick_value();
      b.position = 6'($urandom_range(63));
      send_random(b);
    end
  endtask

  task automatic drain_run();
    in_beat_t b;
    repeat (list_mirror.size() + 2) begin
      case ($urandom_range(2))
        0: b.command = CMD_DEL_HEAD;
        1: b.command = CMD_DEL_TAIL;
        default: b.command = CMD_DEL_VAL;
      endcase
      b.data_value = pick_value();
      b.position = 6'($urandom_range(63));
      send_random(b);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);
  endtask

  function automatic void check_result(out_beat_t got);
    out_beat_t w;
    if (want_q.size() == 0) begin
      $error("unexpected result beat: %h", got);
      fail_count++;
      return;
    end
    w = want_q.pop_front();
    if (got.status !== w.status) begin
      $error("status: expected %0d, got %0d", w.status, got.status);
      fail_count++;
    end
    if (got.result_value !== w.result_value) begin
      $error("result_value: expected %0d, got %0d", w.result_value, got.result_value);
      fail_count++;
    end
    if (got.found_position !== w.found_position) begin
      $error("found_position: expected %0d, got %0d", w.found_position, got.found_position);
      fail_count++;
    end
    if (got.entry_count !== w.entry_count) begin
      $error("entry_count: expected %0d, got %0d", w.entry_count, got.entry_count);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (out_valid_o && out_ready) check_result(out_data_o);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(negedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 81;
    items_sent = 0;
    fail_count = 0;
    quiet_cycles = 0;

    // empty list, extremes, every command, then back to empty
    dir_rows.push_back(dir_row(CMD_COUNT, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_DEL_HEAD, 0, 0, 1, ST_MISS, 0));
    dir_rows.push_back(dir_row(CMD_DEL_TAIL, -1, 63, 1, ST_MISS, 0));
    dir_rows.push_back(dir_row(CMD_FIND, 5, 0, 1, ST_MISS, 0));
    dir_rows.push_back(dir_row(CMD_DEL_VAL, 5, 0, 1, ST_MISS, 0));
    dir_rows.push_back(dir_row(CMD_READ_AT, 0, 0, 1, ST_MISS, 0));
    dir_rows.push_back(dir_row(CMD_EVEN_SUM, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_INS_HEAD, 32'sh7fffffff, 0, 1, ST_OK, 1));
    dir_rows.push_back(dir_row(CMD_INS_TAIL, 32'sh80000000, 63, 1, ST_OK, 2));
    dir_rows.push_back(dir_row(CMD_INS_HEAD, -2, 0, 1, ST_OK, 3));
    dir_rows.push_back(dir_row(CMD_INS_TAIL, 4, 0, 1, ST_OK, 4));
    dir_rows.push_back(dir_row(CMD_READ_AT, 0, 63, 1, ST_MISS, 4));
    dir_rows.push_back(dir_row(CMD_READ_AT, 0, 3, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_FIND, 32'sh80000000, 0, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_EVEN_SUM, 0, 0, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_DEL_VAL, -2, 0, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_LAST_CODE, -1, 63, 1, ST_OK, 3));
    dir_rows.push_back(dir_row(CMD_DEL_TAIL, 0, 0, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_DEL_HEAD, 0, 0, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_READ_AT, 0, 0, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_CLEAR, 0, 0, 1, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_DEL_HEAD, 0, 0, 1, ST_MISS, 0));
    dir_rows.push_back(dir_row(CMD_INS_TAIL, 0, 0, 1, ST_OK, 1));
    dir_rows.push_back(dir_row(CMD_DEL_VAL, 0, 0, 0, ST_OK, 0));
    dir_rows.push_back(dir_row(CMD_COUNT, 0, 0, 1, ST_OK, 0));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 6 : 0;
      items_sent = 0;
      fill_run();
      while (items_sent < PHASE_ITEMS) begin
        case ($urandom_range(5))
          0: drain_run();
          1: fill_run();
          default: repeat (MIXED_RUN) send_random(mixed_beat());
        endcase
      end
      // sender holds off until every result is back
      wait_idle();
    end

    if (fail_count == 0 && want_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
